>>> hdl/pmq_pkg.sv
// Package: shared types, codes and constants for the priority message queue.
`timescale 1ns / 1ps

package pmq_pkg;

  localparam int QUEUE_DEPTH_DEF     = 128;
  localparam int DATA_WIDTH_DEF      = 64;
  localparam int PRIORITY_LEVELS     = 256;

  localparam int PRIO_W              = 8;
  localparam int LEN_W               = 11;
  localparam int MAXMSG_W            = 8;
  localparam int BUF_W               = 16;
  localparam int ID_W                = 8;
  localparam int CMD_W               = 2;
  localparam int STATUS_W            = 2;
  localparam int COUNT_OUT_W         = 8;
  localparam int CFG_DATA_W          = 11;
  localparam int CFG_INDEX_W         = 1;

  localparam logic [MAXMSG_W-1:0] MAX_MESSAGES_RST = MAXMSG_W'(128);
  localparam logic [LEN_W-1:0]    MAX_LENGTH_RST   = LEN_W'(1024);

  localparam logic [PRIO_W-1:0] PRIO_SAT =
    (PRIORITY_LEVELS > 256) ? {PRIO_W{1'b1}} : PRIO_W'(PRIORITY_LEVELS - 1);

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_MESSAGES = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH   = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND    = 2'd0,
    CMD_RECEIVE = 2'd1,
    CMD_ARM     = 2'd2,
    CMD_DISARM  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_SIZE  = 2'd1,
    ST_LIMIT = 2'd2,
    ST_BUSY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [PRIO_W-1:0]   prio;
  } cell_ctrl_t;

endpackage

>>> hdl/pmq_cell.sv
// Cell: one sorted queue slot that holds, takes a new message or shifts along the row.
`timescale 1ns / 1ps

module pmq_cell #(
  parameter int DATA_WIDTH = pmq_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pmq_pkg::cell_ctrl_t          ctrl,
  input  logic [DATA_WIDTH-1:0]        new_data,
  input  logic [pmq_pkg::LEN_W-1:0]    new_length,
  input  logic                         left_ge,
  input  logic                         left_valid,
  input  logic [DATA_WIDTH-1:0]        left_data,
  input  logic [pmq_pkg::LEN_W-1:0]    left_length,
  input  logic [pmq_pkg::PRIO_W-1:0]   left_prio,
  input  logic                         right_valid,
  input  logic [DATA_WIDTH-1:0]        right_data,
  input  logic [pmq_pkg::LEN_W-1:0]    right_length,
  input  logic [pmq_pkg::PRIO_W-1:0]   right_prio,
  output logic                         valid,
  output logic [DATA_WIDTH-1:0]        data,
  output logic [pmq_pkg::LEN_W-1:0]    length,
  output logic [pmq_pkg::PRIO_W-1:0]   prio,
  output logic                         ge
);

  logic                       valid_next;
  logic [DATA_WIDTH-1:0]      data_next;
  logic [pmq_pkg::LEN_W-1:0]  length_next;
  logic [pmq_pkg::PRIO_W-1:0] prio_next;

  assign ge = valid && (prio >= ctrl.prio);

  always_comb begin
    valid_next  = valid;
    data_next   = data;
    length_next = length;
    prio_next   = prio;
    unique case (ctrl.op)
      pmq_pkg::CELL_INSERT: begin
        if (!ge) begin
          if (left_ge) begin
            valid_next  = 1'b1;
            data_next   = new_data;
            length_next = new_length;
            prio_next   = ctrl.prio;
          end else begin
            valid_next  = left_valid;
            data_next   = left_data;
            length_next = left_length;
            prio_next   = left_prio;
          end
        end
      end
      pmq_pkg::CELL_POP: begin
        valid_next  = right_valid;
        data_next   = right_data;
        length_next = right_length;
        prio_next   = right_prio;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    data   <= data_next;
    length <= length_next;
    prio   <= prio_next;
  end

endmodule

>>> hdl/priority_message_queue.sv
// Top level: command decode, limits, notification and the row of sorted queue cells.
// Each result is registered and appears in the cycle after its input transfer.
// Throughput: one item per cycle while in_stall is low; a send is placed by all cells comparing at once.
// The row shifts by one cell per accepted send or receive.
// Reset empties the queue, disarms notification and restores the limit registers.
`timescale 1ns / 1ps

module priority_message_queue #(
  parameter int QUEUE_DEPTH = pmq_pkg::QUEUE_DEPTH_DEF,
  parameter int DATA_WIDTH  = pmq_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pmq_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [pmq_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [pmq_pkg::CMD_W-1:0]          command,
  input  logic [DATA_WIDTH-1:0]              data,
  input  logic [pmq_pkg::LEN_W-1:0]          length,
  input  logic [pmq_pkg::PRIO_W-1:0]         priority_req,
  input  logic [pmq_pkg::BUF_W-1:0]          buffer_len,
  input  logic [pmq_pkg::ID_W-1:0]           requester_id,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pmq_pkg::STATUS_W-1:0]       status,
  output logic [DATA_WIDTH-1:0]              out_data,
  output logic [pmq_pkg::LEN_W-1:0]          out_length,
  output logic [pmq_pkg::PRIO_W-1:0]         out_priority,
  output logic                               notify,
  output logic [pmq_pkg::ID_W-1:0]           notify_target,
  output logic [pmq_pkg::COUNT_OUT_W-1:0]    message_count
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > pmq_pkg::MAXMSG_W) ? CNT_W : pmq_pkg::MAXMSG_W;

  logic [pmq_pkg::MAXMSG_W-1:0] max_messages;
  logic [pmq_pkg::LEN_W-1:0]    max_length;
  logic [CNT_W-1:0]             count;
  logic [CNT_W-1:0]             count_next;
  logic                         armed;
  logic                         armed_next;
  logic [pmq_pkg::ID_W-1:0]     owner;
  logic [pmq_pkg::ID_W-1:0]     owner_next;

  logic                         transfer;
  pmq_pkg::cell_ctrl_t          ctrl;
  pmq_pkg::cmd_t                cmd;
  logic [pmq_pkg::PRIO_W-1:0]   prio_sat;
  logic                         full;

  pmq_pkg::status_t             status_next;
  logic [DATA_WIDTH-1:0]        out_data_next;
  logic [pmq_pkg::LEN_W-1:0]    out_length_next;
  logic [pmq_pkg::PRIO_W-1:0]   out_priority_next;
  logic                         notify_next;
  logic [pmq_pkg::ID_W-1:0]     notify_target_next;

  logic                         c_valid  [QUEUE_DEPTH];
  logic [DATA_WIDTH-1:0]        c_data   [QUEUE_DEPTH];
  logic [pmq_pkg::LEN_W-1:0]    c_length [QUEUE_DEPTH];
  logic [pmq_pkg::PRIO_W-1:0]   c_prio   [QUEUE_DEPTH];
  logic                         c_ge     [QUEUE_DEPTH];

  assign in_stall = out_valid && out_stall;
  assign transfer = in_valid && !in_stall;
  assign cmd      = pmq_pkg::cmd_t'(command);

  assign prio_sat = ({24'd0, priority_req} >= 32'(pmq_pkg::PRIORITY_LEVELS)) ?
                    pmq_pkg::PRIO_SAT : priority_req;

  assign full = (CMP_W'(count) >= CMP_W'(max_messages)) ||
                (count >= CNT_W'(QUEUE_DEPTH));

  always_comb begin
    ctrl.op            = pmq_pkg::CELL_HOLD;
    ctrl.prio          = prio_sat;
    count_next         = count;
    armed_next         = armed;
    owner_next         = owner;
    status_next        = pmq_pkg::ST_OK;
    out_data_next      = '0;
    out_length_next    = '0;
    out_priority_next  = '0;
    notify_next        = 1'b0;
    notify_target_next = '0;
    unique case (cmd)
      pmq_pkg::CMD_SEND: begin
        if (length > max_length) begin
          status_next = pmq_pkg::ST_SIZE;
        end else if (full) begin
          status_next = pmq_pkg::ST_LIMIT;
        end else begin
          ctrl.op    = pmq_pkg::CELL_INSERT;
          count_next = count + CNT_W'(1);
          if ((count == '0) && armed) begin
            notify_next        = 1'b1;
            notify_target_next = owner;
            armed_next         = 1'b0;
          end
        end
      end
      pmq_pkg::CMD_RECEIVE: begin
        if (buffer_len < pmq_pkg::BUF_W'(max_length)) begin
          status_next = pmq_pkg::ST_SIZE;
        end else if (count == '0) begin
          status_next = pmq_pkg::ST_LIMIT;
        end else begin
          ctrl.op           = pmq_pkg::CELL_POP;
          count_next        = count - CNT_W'(1);
          out_data_next     = c_data[0];
          out_length_next   = c_length[0];
          out_priority_next = c_prio[0];
        end
      end
      pmq_pkg::CMD_ARM: begin
        if (armed) begin
          status_next = pmq_pkg::ST_BUSY;
        end else begin
          armed_next = 1'b1;
          owner_next = requester_id;
        end
      end
      pmq_pkg::CMD_DISARM: begin
        if (armed && (owner == requester_id)) begin
          armed_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
    if (!transfer) begin
      ctrl.op = pmq_pkg::CELL_HOLD;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                       l_ge;
    logic                       l_valid;
    logic [DATA_WIDTH-1:0]      l_data;
    logic [pmq_pkg::LEN_W-1:0]  l_length;
    logic [pmq_pkg::PRIO_W-1:0] l_prio;
    logic                       r_valid;
    logic [DATA_WIDTH-1:0]      r_data;
    logic [pmq_pkg::LEN_W-1:0]  r_length;
    logic [pmq_pkg::PRIO_W-1:0] r_prio;

    if (i == 0) begin : g_first
      assign l_ge     = 1'b1;
      assign l_valid  = 1'b0;
      assign l_data   = '0;
      assign l_length = '0;
      assign l_prio   = '0;
    end else begin : g_mid_l
      assign l_ge     = c_ge[i-1];
      assign l_valid  = c_valid[i-1];
      assign l_data   = c_data[i-1];
      assign l_length = c_length[i-1];
      assign l_prio   = c_prio[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign r_valid  = 1'b0;
      assign r_data   = '0;
      assign r_length = '0;
      assign r_prio   = '0;
    end else begin : g_mid_r
      assign r_valid  = c_valid[i+1];
      assign r_data   = c_data[i+1];
      assign r_length = c_length[i+1];
      assign r_prio   = c_prio[i+1];
    end

    pmq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctrl         (ctrl),
      .new_data     (data),
      .new_length   (length),
      .left_ge      (l_ge),
      .left_valid   (l_valid),
      .left_data    (l_data),
      .left_length  (l_length),
      .left_prio    (l_prio),
      .right_valid  (r_valid),
      .right_data   (r_data),
      .right_length (r_length),
      .right_prio   (r_prio),
      .valid        (c_valid[i]),
      .data         (c_data[i]),
      .length       (c_length[i]),
      .prio         (c_prio[i]),
      .ge           (c_ge[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_messages <= pmq_pkg::MAX_MESSAGES_RST;
      max_length   <= pmq_pkg::MAX_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pmq_pkg::CFG_MAX_MESSAGES: max_messages <= cfg_data[pmq_pkg::MAXMSG_W-1:0];
        pmq_pkg::CFG_MAX_LENGTH:   max_length   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      armed     <= 1'b0;
      owner     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (transfer) begin
        count     <= count_next;
        armed     <= armed_next;
        owner     <= owner_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (transfer) begin
      status        <= status_next;
      out_data      <= out_data_next;
      out_length    <= out_length_next;
      out_priority  <= out_priority_next;
      notify        <= notify_next;
      notify_target <= notify_target_next;
      message_count <= pmq_pkg::COUNT_OUT_W'(count_next);
    end
  end

endmodule

>>> tb/sv/tb_priority_message_queue.sv
// Testbench for priority_message_queue: directed table, random traffic, sorted-queue predictor.
`timescale 1ns / 1ps

module tb_priority_message_queue;

  localparam int QUEUE_SLOTS = pmq_pkg::QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DIR_ROWS    = 26;

  typedef struct packed {
    pmq_pkg::cmd_t                cmd;
    logic [63:0]                  data;
    logic [pmq_pkg::LEN_W-1:0]    len;
    logic [pmq_pkg::PRIO_W-1:0]   prio;
    logic [pmq_pkg::BUF_W-1:0]    buf_len;
    logic [pmq_pkg::ID_W-1:0]     id;
  } item_t;

  typedef struct packed {
    pmq_pkg::status_t                  status;
    logic [63:0]                       data;
    logic [pmq_pkg::LEN_W-1:0]         len;
    logic [pmq_pkg::PRIO_W-1:0]        prio;
    logic                              notify;
    logic [pmq_pkg::ID_W-1:0]          target;
    logic [pmq_pkg::COUNT_OUT_W-1:0]   count;
  } result_t;

  typedef struct packed {
    logic [63:0]                  data;
    logic [pmq_pkg::LEN_W-1:0]    len;
    logic [pmq_pkg::PRIO_W-1:0]   prio;
  } msg_t;

  typedef struct packed {
    item_t    it;
    logic     typed;
    result_t  want;
  } step_row_t;

  typedef enum logic [1:0] {
    STALL_NONE  = 2'd0,
    STALL_COIN  = 2'd1,
    STALL_THIRD = 2'd2,
    STALL_HEAVY = 2'd3
  } stall_mode_t;

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                cfg_we = 1'b0;
  logic [pmq_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
  logic [pmq_pkg::CFG_DATA_W-1:0]      cfg_data = '0;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [pmq_pkg::CMD_W-1:0]           command = '0;
  logic [63:0]                         data = '0;
  logic [pmq_pkg::LEN_W-1:0]           length = '0;
  logic [pmq_pkg::PRIO_W-1:0]          priority_req = '0;
  logic [pmq_pkg::BUF_W-1:0]           buffer_len = '0;
  logic [pmq_pkg::ID_W-1:0]            requester_id = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [pmq_pkg::STATUS_W-1:0]        status;
  logic [63:0]                         out_data;
  logic [pmq_pkg::LEN_W-1:0]           out_length;
  logic [pmq_pkg::PRIO_W-1:0]          out_priority;
  logic                                notify;
  logic [pmq_pkg::ID_W-1:0]            notify_target;
  logic [pmq_pkg::COUNT_OUT_W-1:0]     message_count;

  priority_message_queue uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .data(data), .length(length), .priority_req(priority_req),
    .buffer_len(buffer_len), .requester_id(requester_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .out_data(out_data), .out_length(out_length),
    .out_priority(out_priority), .notify(notify), .notify_target(notify_target),
    .message_count(message_count)
  );

  msg_t                        held_msgs[$];
  result_t                     pending_results[$];
  logic [7:0]                  limit_msgs = pmq_pkg::MAX_MESSAGES_RST;
  logic [pmq_pkg::LEN_W-1:0]   limit_len = pmq_pkg::MAX_LENGTH_RST;
  logic                        armed = 1'b0;
  logic [pmq_pkg::ID_W-1:0]    owner = '0;
  int                          fail_count = 0;
  int                          cycles = 0;
  int                          burst_left = 0;
  stall_mode_t                 stall_mode = STALL_NONE;
  int                          stall_left = 0;

  step_row_t dir_table [DIR_ROWS] = '{
    '{'{pmq_pkg::CMD_RECEIVE, 64'h0, 11'd0, 8'd0, 16'd1024, 8'h00}, 1'b1,
      '{pmq_pkg::ST_LIMIT, 64'h0, 11'd0, 8'd0, 1'b0, 8'h00, 8'd0}},
    '{'{pmq_pkg::CMD_RECEIVE, 64'h0, 11'd0, 8'd0, 16'd1023, 8'h00}, 1'b1,
      '{pmq_pkg::ST_SIZE, 64'h0, 11'd0, 8'd0, 1'b0, 8'h00, 8'd0}},
    '{'{pmq_pkg::CMD_DISARM, 64'h0, 11'd0, 8'd0, 16'd0, 8'h05}, 1'b1,
      '{pmq_pkg::ST_OK, 64'h0, 11'd0, 8'd0, 1'b0, 8'h00, 8'd0}},
    '{'{pmq_pkg::CMD_ARM, 64'h0, 11'd0, 8'd0, 16'd0, 8'hA5}, 1'b1,
      '{pmq_pkg::ST_OK, 64'h0, 11'd0, 8'd0, 1'b0, 8'h00, 8'd0}},
    '{'{pmq_pkg::CMD_ARM, 64'h0, 11'd0, 8'd0, 16'd0, 8'h5A}, 1'b1,
      '{pmq_pkg::ST_BUSY, 64'h0, 11'd0, 8'd0, 1'b0, 8'h00, 8'd0}},
    '{'{pmq_pkg::CMD_DISARM, 64'h0, 11'd0, 8'd0, 16'd0, 8'h5A}, 1'b1,
      '{pmq_pkg::ST_OK, 64'h0, 11'd0, 8'd0, 1'b0, 8'h00, 8'd0}},
    '{'{pmq_pkg::CMD_SEND, 64'h1, 11'd1025, 8'd3, 16'd0, 8'h00}, 1'b1,
      '{pmq_pkg::ST_SIZE, 64'h0, 11'd0, 8'd0, 1'b0, 8'h00, 8'd0}},
    '{'{pmq_pkg::CMD_SEND, 64'h2, 11'd2047, 8'd255, 16'hFFFF, 8'hFF}, 1'b1,
      '{pmq_pkg::ST_SIZE, 64'h0, 11'd0, 8'd0, 1'b0, 8'h00, 8'd0}},
    '{'{pmq_pkg::CMD_SEND, 64'hFFFF_FFFF_FFFF_FFFF, 11'd1024, 8'd0, 16'd0, 8'h00}, 1'b1,
      '{pmq_pkg::ST_OK, 64'h0, 11'd0, 8'd0, 1'b1, 8'hA5, 8'd1}},
    '{'{pmq_pkg::CMD_SEND, 64'h0, 11'd0, 8'd255, 16'd0, 8'h00}, 1'b1,
      '{pmq_pkg::ST_OK, 64'h0, 11'd0, 8'd0, 1'b0, 8'h00, 8'd2}},
    '{'{pmq_pkg::CMD_SEND, 64'h0123_4567_89AB_CDEF, 11'd5, 8'd255, 16'd0, 8'h00}, 1'b1,
      '{pmq_pkg::ST_OK, 64'h0, 11'd0, 8'd0, 1'b0, 8'h00, 8'd3}},
    '{'{pmq_pkg::CMD_SEND, 64'h8000_0000_0000_0000, 11'd1, 8'h80, 16'd0, 8'h00}, 1'b1,
      '{pmq_pkg::ST_OK, 64'h0, 11'd0, 8'd0, 1'b0, 8'h00, 8'd4}},
    '{'{pmq_pkg::CMD_SEND, 64'h5555_AAAA_5555_AAAA, 11'd1023, 8'd0, 16'd0, 8'h00}, 1'b0,
      '0},
    '{'{pmq_pkg::CMD_RECEIVE, 64'h0, 11'd0, 8'd0, 16'hFFFF, 8'h00}, 1'b1,
      '{pmq_pkg::ST_OK, 64'h0, 11'd0, 8'd255, 1'b0, 8'h00, 8'd4}},
    '{'{pmq_pkg::CMD_RECEIVE, 64'h0, 11'd0, 8'd0, 16'd1024, 8'h00}, 1'b1,
      '{pmq_pkg::ST_OK, 64'h0123_4567_89AB_CDEF, 11'd5, 8'd255, 1'b0, 8'h00, 8'd3}},
    '{'{pmq_pkg::CMD_RECEIVE, 64'h0, 11'd0, 8'd0, 16'h8000, 8'h00}, 1'b1,
      '{pmq_pkg::ST_OK, 64'h8000_0000_0000_0000, 11'd1, 8'h80, 1'b0, 8'h00, 8'd2}},
    '{'{pmq_pkg::CMD_ARM, 64'h0, 11'd0, 8'd0, 16'd0, 8'hFF}, 1'b1,
      '{pmq_pkg::ST_OK, 64'h0, 11'd0, 8'd0, 1'b0, 8'h00, 8'd2}},
    '{'{pmq_pkg::CMD_RECEIVE, 64'h0, 11'd0, 8'd0, 16'd2000, 8'h00}, 1'b0, '0},
    '{'{pmq_pkg::CMD_RECEIVE, 64'h0, 11'd0, 8'd0, 16'd1024, 8'h00}, 1'b0, '0},
    '{'{pmq_pkg::CMD_RECEIVE, 64'h0, 11'd0, 8'd0, 16'd1024, 8'h00}, 1'b1,
      '{pmq_pkg::ST_LIMIT, 64'h0, 11'd0, 8'd0, 1'b0, 8'h00, 8'd0}},
    '{'{pmq_pkg::CMD_SEND, 64'h1, 11'd7, 8'd7, 16'd0, 8'h00}, 1'b1,
      '{pmq_pkg::ST_OK, 64'h0, 11'd0, 8'd0, 1'b1, 8'hFF, 8'd1}},
    '{'{pmq_pkg::CMD_ARM, 64'h0, 11'd0, 8'd0, 16'd0, 8'h00}, 1'b0, '0},
    '{'{pmq_pkg::CMD_DISARM, 64'h0, 11'd0, 8'd0, 16'd0, 8'h00}, 1'b0, '0},
    '{'{pmq_pkg::CMD_RECEIVE, 64'h0, 11'd0, 8'd0, 16'd1024, 8'h00}, 1'b0, '0},
    '{'{pmq_pkg::CMD_SEND, 64'h2, 11'd2, 8'd2, 16'd0, 8'h00}, 1'b0, '0},
    '{'{pmq_pkg::CMD_RECEIVE, 64'h0, 11'd0, 8'd0, 16'd1024, 8'h00}, 1'b0, '0}
  };

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic result_t queue_apply(input item_t it);
    result_t r;
    msg_t    m;
    int      pos;
    r = '0;
    case (it.cmd)
      pmq_pkg::CMD_SEND: begin
        if (it.len > limit_len) begin
          r.status = pmq_pkg::ST_SIZE;
        end else if (held_msgs.size() >= limit_msgs || held_msgs.size() >= QUEUE_SLOTS) begin
          r.status = pmq_pkg::ST_LIMIT;
        end else begin
          m = '{it.data, it.len, it.prio};
          pos = 0;
          // keep arrival order among equal priorities
          while (pos < held_msgs.size() && held_msgs[pos].prio >= it.prio) pos++;
          if (held_msgs.size() == 0 && armed) begin
            r.notify = 1'b1;
            r.target = owner;
            armed = 1'b0;
          end
          held_msgs.insert(pos, m);
        end
      end
      pmq_pkg::CMD_RECEIVE: begin
        if (it.buf_len < limit_len) begin
          r.status = pmq_pkg::ST_SIZE;
        end else if (held_msgs.size() == 0) begin
          r.status = pmq_pkg::ST_LIMIT;
        end else begin
          m = held_msgs.pop_front();
          r.data = m.data;
          r.len = m.len;
          r.prio = m.prio;
        end
      end
      pmq_pkg::CMD_ARM: begin
        if (armed) begin
          r.status = pmq_pkg::ST_BUSY;
        end else begin
          armed = 1'b1;
          owner = it.id;
        end
      end
      default: begin
        if (armed && owner == it.id) armed = 1'b0;
      end
    endcase
    r.count = pmq_pkg::COUNT_OUT_W'(held_msgs.size());
    return r;
  endfunction

  function automatic item_t random_item(input int send_pct, input int recv_pct);
    item_t it;
    int    pick;
    pick = $urandom_range(0, 99);
    if (pick < send_pct) it.cmd = pmq_pkg::CMD_SEND;
    else if (pick < send_pct + recv_pct) it.cmd = pmq_pkg::CMD_RECEIVE;
    else if ($urandom_range(0, 1) == 1) it.cmd = pmq_pkg::CMD_ARM;
    else it.cmd = pmq_pkg::CMD_DISARM;
    it.data = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: it.len = pmq_pkg::LEN_W'($urandom_range(int'(limit_len) + 1, 2047));
      1: it.len = limit_len;
      2: it.len = '0;
      default: it.len = pmq_pkg::LEN_W'($urandom_range(0, int'(limit_len)));
    endcase
    if ($urandom_range(0, 1) == 1) it.prio = pmq_pkg::PRIO_W'($urandom_range(0, 255));
    else it.prio = pmq_pkg::PRIO_W'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: it.buf_len = pmq_pkg::BUF_W'($urandom_range(0, int'(limit_len) - 1));
      1: it.buf_len = pmq_pkg::BUF_W'(limit_len);
      default: it.buf_len = pmq_pkg::BUF_W'($urandom_range(int'(limit_len), 65535));
    endcase
    if (armed && $urandom_range(0, 1) == 1) it.id = owner;
    else it.id = pmq_pkg::ID_W'($urandom_range(0, 255));
    return it;
  endfunction

  task automatic transfer_item(input item_t it, input logic typed, input result_t want);
    int      gap;
    result_t r;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    command = it.cmd;
    data = it.data;
    length = it.len;
    priority_req = it.prio;
    buffer_len = it.buf_len;
    requester_id = it.id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = queue_apply(it);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic release_inputs();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_limit(input logic [pmq_pkg::CFG_INDEX_W-1:0] idx, input int value);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = pmq_pkg::CFG_DATA_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == pmq_pkg::CFG_MAX_MESSAGES) limit_msgs = 8'(value);
    else limit_len = pmq_pkg::LEN_W'(value);
  endtask

  task automatic random_traffic(input int items, input int send_pct, input int recv_pct);
    for (int i = 0; i < items; i++) transfer_item(random_item(send_pct, recv_pct), 1'b0, '0);
    release_inputs();
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_mode)
      STALL_NONE:  out_stall = 1'b0;
      STALL_COIN:  out_stall = ($urandom_range(0, 1) == 1);
      STALL_THIRD: out_stall = (stall_left % 3 == 0);
      default:     out_stall = ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result, expected none, actual status %0h", $time, status);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 64'(want.status), 64'(status));
        check_field("out_data", want.data, out_data);
        check_field("out_length", 64'(want.len), 64'(out_length));
        check_field("out_priority", 64'(want.prio), 64'(out_priority));
        check_field("notify", 64'(want.notify), 64'(notify));
        check_field("notify_target", 64'(want.target), 64'(notify_target));
        check_field("message_count", 64'(want.count), 64'(message_count));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("[priority_message_queue] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_table[i]) transfer_item(dir_table[i].it, dir_table[i].typed, dir_table[i].want);
    release_inputs();

    write_limit(pmq_pkg::CFG_MAX_MESSAGES, 1);
    write_limit(pmq_pkg::CFG_MAX_LENGTH, 1);
    random_traffic(100, 45, 35);

    // fill to the slot limit, then drain
    write_limit(pmq_pkg::CFG_MAX_MESSAGES, 128);
    write_limit(pmq_pkg::CFG_MAX_LENGTH, 1024);
    random_traffic(300, 80, 10);
    random_traffic(150, 20, 70);

    write_limit(pmq_pkg::CFG_MAX_MESSAGES, $urandom_range(2, 127));
    write_limit(pmq_pkg::CFG_MAX_LENGTH, $urandom_range(1, 1023));
    random_traffic(150, 50, 40);

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[priority_message_queue] OK");
    end else begin
      $display("[priority_message_queue] ERROR");
    end
    $finish;
  end

endmodule

>>> priority_message_queue.f
hdl/pmq_pkg.sv
hdl/pmq_cell.sv
hdl/priority_message_queue.sv
tb/sv/tb_priority_message_queue.sv
